FILE: rtl/sync_serial_frame_transceiver_top_defines.svh
// Assertion macros shared by the serial frame transceiver modules.
`ifndef SYNC_SERIAL_FRAME_TRANSCEIVER_TOP_DEFINES_SVH
`define SYNC_SERIAL_FRAME_TRANSCEIVER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSFT_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSFT_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ssft_pkg.sv
// Types and constants shared by the serial frame transceiver modules.
`default_nettype none

package ssft_pkg;

   // Defaults for the top-level parameters.
   localparam int DATA_BITS_DEF   = 8;
   localparam int QUEUE_DEPTH_DEF = 2;

   // Field widths.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Register reset values.
   localparam logic [15:0] START_WAIT_RESET = 16'd1000;

   // Parity mode codes; any other code means no parity.
   localparam logic [1:0] PARITY_EVEN = 2'd1;
   localparam logic [1:0] PARITY_ODD  = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLED     = 3'd0,
      CSR_PARITY_MODE = 3'd1,
      CSR_TWO_STOP    = 3'd2,
      CSR_HALF_PERIOD = 3'd3,
      CSR_START_WAIT  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      REQ_NONE  = 2'd0,
      REQ_SEND  = 2'd1,
      REQ_RECV  = 2'd2,
      REQ_PULSE = 2'd3
   } req_kind_type;

   // Request classes produced by the front end.
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_REJECT,
      CMD_SEND,
      CMD_RECV,
      CMD_RECV_EMPTY,
      CMD_PULSE,
      CMD_PULSE_EMPTY
   } cmd_kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_TX,
      MODE_RX,
      MODE_PULSE
   } mode_type;

   typedef enum logic [2:0] {
      PH_START,
      PH_DATA,
      PH_PARITY,
      PH_STOP1,
      PH_STOP2
   } phase_type;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_REJECTED   = 3'd1,
      STATUS_TIMEOUT    = 3'd2,
      STATUS_PARITY_ERR = 3'd3,
      STATUS_STOP1_ERR  = 3'd4,
      STATUS_STOP2_ERR  = 3'd5
   } status_type;

   typedef struct packed {
      logic        enabled;
      logic [1:0]  parity_mode;
      logic        two_stop_bits;
      logic [15:0] start_wait_limit;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   tx_byte;
      logic [15:0]  count;
      logic         pulse_level;
      logic         rxd_sample;
   } cmd_type;

   typedef struct packed {
      logic       txd_level;
      logic       xck_pulse;
      logic       busy_res;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       done_res;
      status_type status;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/ssft_queue.sv
// Small register-based first-in first-out queue used between the pipeline parts.
`default_nettype none

`include "sync_serial_frame_transceiver_top_defines.svh"

module ssft_queue import ssft_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots hold payload only.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `SSFT_ASSERT_IMP(a_no_write_when_full, wr_en, !full, "queue written while full")
   `SSFT_ASSERT_IMP(a_no_read_when_empty, rd_en, !empty, "queue read while empty")
   `SSFT_ASSERT_NEXT(a_write_fills, wr_en && !rd_en, !empty, "queue empty after a write")

endmodule

`default_nettype wire

FILE: rtl/ssft_front.sv
// Front end: accepts request items and classifies them for the bit engine.
`default_nettype none

module ssft_front import ssft_pkg::*; (
   input  wire logic        push,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_tx_byte,
   input  wire logic [15:0] req_count,
   input  wire logic        req_pulse_level,
   input  wire logic        req_slave_selected,
   input  wire logic        req_rxd_sample,
   input  wire logic        enabled,
   input  wire logic        queue_full,
   output logic             cmd_push,
   output cmd_type          cmd
);

   logic count_zero;

   assign count_zero = (req_count == '0);
   assign cmd_push   = push && !queue_full;

   // A request is classified once; whether it starts is decided by the engine.
   always_comb begin
      cmd.tx_byte     = req_tx_byte;
      cmd.count       = req_count;
      cmd.pulse_level = req_pulse_level;
      cmd.rxd_sample  = req_rxd_sample;
      cmd.kind        = CMD_NONE;
      if (req_kind_type'(req_type) != REQ_NONE && (!enabled || !req_slave_selected)) begin
         cmd.kind = CMD_REJECT;
      end else begin
         case (req_kind_type'(req_type))
            REQ_SEND:  cmd.kind = CMD_SEND;
            REQ_RECV:  cmd.kind = count_zero ? CMD_RECV_EMPTY : CMD_RECV;
            REQ_PULSE: cmd.kind = count_zero ? CMD_PULSE_EMPTY : CMD_PULSE;
            default:   cmd.kind = CMD_NONE;
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ssft_back.sv
// Back end: bit engine that runs one bit period for every classified item.
`default_nettype none

`include "sync_serial_frame_transceiver_top_defines.svh"

module ssft_back import ssft_pkg::*; #(
   parameter int DATA_BITS = DATA_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire cmd_type cmd,
   input  wire logic    cmd_valid,
   input  wire logic    rsp_ready,
   output logic         fire,
   output rsp_type      rsp
);

   localparam int BIDX_W  = $clog2(DATA_BITS + 1);
   localparam int SHIFT_W = (DATA_BITS > 8) ? DATA_BITS : 8;
   localparam logic [BIDX_W-1:0] LAST_BIT = BIDX_W'(DATA_BITS);

   mode_type           op_mode_ff, mode_in;
   phase_type          phase_ff, phase_in;
   logic [BIDX_W-1:0]  bidx_ff, bidx_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic               par_ff, par_in;
   logic [15:0]        wait_ff, wait_in;
   logic [15:0]        rem_ff, rem_in;
   logic               txd_ff, txd_in;

   mode_type           eff_mode;
   phase_type          eff_phase;
   logic [SHIFT_W-1:0] eff_shift;
   logic [15:0]        eff_rem;
   logic [15:0]        eff_wait;
   logic               eff_txd;
   logic [SHIFT_W-1:0] shift_v;
   logic [BIDX_W-1:0]  bidx_nxt;
   logic [16:0]        wait_inc;
   logic [15:0]        rem_dec;
   logic               tx_bit;
   logic               parity_on;
   logic               parity_odd;

   assign fire       = cmd_valid && rsp_ready;
   assign parity_on  = (cfg.parity_mode == PARITY_EVEN) || (cfg.parity_mode == PARITY_ODD);
   assign parity_odd = (cfg.parity_mode == PARITY_ODD);

   // Next state and result of one bit period.
   always_comb begin
      eff_mode  = op_mode_ff;
      eff_phase = phase_ff;
      eff_shift = shift_ff;
      eff_rem   = rem_ff;
      eff_wait  = wait_ff;
      eff_txd   = txd_ff;

      rsp.txd_level = txd_ff;
      rsp.xck_pulse = 1'b0;
      rsp.busy_res  = 1'b0;
      rsp.rx_byte   = '0;
      rsp.rx_valid  = 1'b0;
      rsp.done_res  = 1'b0;
      rsp.status    = STATUS_OK;

      // A new request is taken only while idle and runs its first period at once.
      if (op_mode_ff == MODE_IDLE) begin
         case (cmd.kind)
            CMD_REJECT: begin
               rsp.done_res = 1'b1;
               rsp.status   = STATUS_REJECTED;
            end
            CMD_SEND: begin
               eff_mode  = MODE_TX;
               eff_phase = PH_START;
               eff_shift = SHIFT_W'(cmd.tx_byte);
            end
            CMD_RECV: begin
               eff_mode  = MODE_RX;
               eff_phase = PH_START;
               eff_rem   = cmd.count;
               eff_wait  = '0;
            end
            CMD_RECV_EMPTY: begin
               rsp.done_res = 1'b1;
            end
            CMD_PULSE: begin
               eff_mode = MODE_PULSE;
               eff_rem  = cmd.count;
               eff_txd  = cmd.pulse_level;
            end
            CMD_PULSE_EMPTY: begin
               eff_txd       = cmd.pulse_level;
               rsp.txd_level = cmd.pulse_level;
               rsp.done_res  = 1'b1;
            end
            default: begin
            end
         endcase
      end

      mode_in  = eff_mode;
      phase_in = eff_phase;
      bidx_in  = bidx_ff;
      shift_in = eff_shift;
      par_in   = par_ff;
      wait_in  = eff_wait;
      rem_in   = eff_rem;
      txd_in   = eff_txd;

      shift_v  = eff_shift;
      bidx_nxt = bidx_ff + 1'b1;
      wait_inc = {1'b0, eff_wait} + 17'd1;
      rem_dec  = eff_rem - 16'd1;
      tx_bit   = 1'b1;

      case (eff_mode)
         // Transmit: start, data LSB first, optional parity, one or two stops.
         MODE_TX: begin
            case (eff_phase)
               PH_START: begin
                  tx_bit   = 1'b0;
                  phase_in = PH_DATA;
                  bidx_in  = '0;
                  par_in   = 1'b0;
               end
               PH_DATA: begin
                  tx_bit   = eff_shift[0];
                  shift_in = eff_shift >> 1;
                  par_in   = par_ff ^ eff_shift[0];
                  bidx_in  = bidx_nxt;
                  if (bidx_nxt >= LAST_BIT) begin
                     phase_in = parity_on ? PH_PARITY : PH_STOP1;
                  end
               end
               PH_PARITY: begin
                  tx_bit   = par_ff ^ parity_odd;
                  phase_in = PH_STOP1;
               end
               PH_STOP1: begin
                  if (cfg.two_stop_bits) begin
                     phase_in = PH_STOP2;
                  end else begin
                     mode_in      = MODE_IDLE;
                     phase_in     = PH_START;
                     rsp.done_res = 1'b1;
                  end
               end
               default: begin
                  mode_in      = MODE_IDLE;
                  phase_in     = PH_START;
                  rsp.done_res = 1'b1;
               end
            endcase
            txd_in        = tx_bit;
            rsp.txd_level = tx_bit;
            rsp.xck_pulse = 1'b1;
         end

         // Receive: hunt for the start bit, then sample and check the frame.
         MODE_RX: begin
            rsp.xck_pulse = 1'b1;
            case (eff_phase)
               PH_START: begin
                  if (!cmd.rxd_sample) begin
                     phase_in = PH_DATA;
                     bidx_in  = '0;
                     shift_in = '0;
                     par_in   = 1'b0;
                  end else begin
                     wait_in = wait_inc[15:0];
                     if (wait_inc >= {1'b0, cfg.start_wait_limit}) begin
                        mode_in      = MODE_IDLE;
                        phase_in     = PH_START;
                        rsp.done_res = 1'b1;
                        rsp.status   = STATUS_TIMEOUT;
                     end
                  end
               end
               PH_DATA: begin
                  shift_v  = (eff_shift >> 1)
                           | (SHIFT_W'(cmd.rxd_sample) << (DATA_BITS - 1));
                  shift_in = shift_v;
                  par_in   = par_ff ^ cmd.rxd_sample;
                  bidx_in  = bidx_nxt;
                  if (bidx_nxt >= LAST_BIT) begin
                     rsp.rx_valid = 1'b1;
                     rsp.rx_byte  = shift_v[7:0];
                     phase_in     = parity_on ? PH_PARITY : PH_STOP1;
                  end
               end
               PH_PARITY: begin
                  if (cmd.rxd_sample != (par_ff ^ parity_odd)) begin
                     mode_in      = MODE_IDLE;
                     phase_in     = PH_START;
                     rsp.done_res = 1'b1;
                     rsp.status   = STATUS_PARITY_ERR;
                  end else begin
                     phase_in = PH_STOP1;
                  end
               end
               PH_STOP1: begin
                  if (!cmd.rxd_sample) begin
                     mode_in      = MODE_IDLE;
                     phase_in     = PH_START;
                     rsp.done_res = 1'b1;
                     rsp.status   = STATUS_STOP1_ERR;
                  end else if (cfg.two_stop_bits) begin
                     phase_in = PH_STOP2;
                  end else begin
                     rem_in = rem_dec;
                     if (rem_dec == '0) begin
                        mode_in      = MODE_IDLE;
                        phase_in     = PH_START;
                        rsp.done_res = 1'b1;
                     end else begin
                        phase_in = PH_START;
                        wait_in  = '0;
                     end
                  end
               end
               default: begin
                  if (!cmd.rxd_sample) begin
                     mode_in      = MODE_IDLE;
                     phase_in     = PH_START;
                     rsp.done_res = 1'b1;
                     rsp.status   = STATUS_STOP2_ERR;
                  end else begin
                     rem_in = rem_dec;
                     if (rem_dec == '0) begin
                        mode_in      = MODE_IDLE;
                        phase_in     = PH_START;
                        rsp.done_res = 1'b1;
                     end else begin
                        phase_in = PH_START;
                        wait_in  = '0;
                     end
                  end
               end
            endcase
         end

         // Pulse train at a held TXD level.
         MODE_PULSE: begin
            rsp.txd_level = eff_txd;
            rsp.xck_pulse = 1'b1;
            rem_in        = rem_dec;
            if (rem_dec == '0) begin
               mode_in      = MODE_IDLE;
               phase_in     = PH_START;
               rsp.done_res = 1'b1;
            end
         end

         default: begin
         end
      endcase

      rsp.busy_res = (mode_in != MODE_IDLE);
   end

   // Operating mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff <= MODE_IDLE;
      end else if (fire) begin
         op_mode_ff <= mode_in;
      end
   end

   // Frame progress registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         bidx_ff  <= '0;
         shift_ff <= '0;
         par_ff   <= 1'b0;
         wait_ff  <= '0;
         rem_ff   <= '0;
         txd_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         bidx_ff  <= bidx_in;
         shift_ff <= shift_in;
         par_ff   <= par_in;
         wait_ff  <= wait_in;
         rem_ff   <= rem_in;
         txd_ff   <= txd_in;
      end
   end

   `SSFT_ASSERT_IMP(a_error_ends_request, fire && rsp.status != STATUS_OK, rsp.done_res && !rsp.busy_res, "error status without end of request")
   `SSFT_ASSERT_IMP(a_byte_only_in_rx, fire && rsp.rx_valid, op_mode_ff == MODE_RX && phase_ff == PH_DATA, "received byte outside a data phase")

endmodule

`default_nettype wire

FILE: rtl/sync_serial_frame_transceiver_top.sv
// Throughput: one item per cycle while no queue is full; each item is one bit period.
// An accepted item waits in the request queue; the engine then writes its result into the
// result queue, whose head drives the rsp_ ports and can be popped from there.
// The bit engine runs one period per cycle while the request queue holds an item and the result queue
// has room; either queue filling up stalls its side. Reset is synchronous and active high: queues empty,
// engine idle, TXD low, registers back to disabled, no parity, one stop bit and a start wait of 1000.
`default_nettype none

module sync_serial_frame_transceiver_top import ssft_pkg::*; #(
   parameter int DATA_BITS   = DATA_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request side.
   input  wire logic                   push,
   output logic                        full,
   input  wire logic [1:0]             req_type,
   input  wire logic [7:0]             req_tx_byte,
   input  wire logic [15:0]            req_count,
   input  wire logic                   req_pulse_level,
   input  wire logic                   req_slave_selected,
   input  wire logic                   req_rxd_sample,
   // Result side.
   output logic                        empty,
   input  wire logic                   pop,
   output logic                        rsp_txd_level,
   output logic                        rsp_xck_pulse,
   output logic                        rsp_busy_res,
   output logic [7:0]                  rsp_rx_byte,
   output logic                        rsp_rx_valid,
   output logic                        rsp_done_res,
   output logic [2:0]                  rsp_status,
   // Register write port.
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   cfg_type cfg_ff;
   cmd_type front_cmd;
   cmd_type head_cmd;
   rsp_type engine_rsp;
   rsp_type out_rsp;
   logic    cmd_push;
   logic    cmd_empty;
   logic    rsp_full;
   logic    fire;

   // Register writes; the XCK phase length has no effect at item level.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled          <= 1'b0;
         cfg_ff.parity_mode      <= '0;
         cfg_ff.two_stop_bits    <= 1'b0;
         cfg_ff.start_wait_limit <= START_WAIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLED:     cfg_ff.enabled          <= csr_wdata[0];
            CSR_PARITY_MODE: cfg_ff.parity_mode      <= csr_wdata[1:0];
            CSR_TWO_STOP:    cfg_ff.two_stop_bits    <= csr_wdata[0];
            CSR_START_WAIT:  cfg_ff.start_wait_limit <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   ssft_front u_front (
      .push               (push),
      .req_type           (req_type),
      .req_tx_byte        (req_tx_byte),
      .req_count          (req_count),
      .req_pulse_level    (req_pulse_level),
      .req_slave_selected (req_slave_selected),
      .req_rxd_sample     (req_rxd_sample),
      .enabled            (cfg_ff.enabled),
      .queue_full         (full),
      .cmd_push           (cmd_push),
      .cmd                (front_cmd)
   );

   // Request queue between the front end and the bit engine.
   ssft_queue #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (front_cmd),
      .full    (full),
      .rd_en   (fire),
      .rd_data (head_cmd),
      .empty   (cmd_empty)
   );

   ssft_back #(
      .DATA_BITS (DATA_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (head_cmd),
      .cmd_valid (!cmd_empty),
      .rsp_ready (!rsp_full),
      .fire      (fire),
      .rsp       (engine_rsp)
   );

   // Result queue towards the consumer.
   ssft_queue #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fire),
      .wr_data (engine_rsp),
      .full    (rsp_full),
      .rd_en   (pop && !empty),
      .rd_data (out_rsp),
      .empty   (empty)
   );

   assign rsp_txd_level = out_rsp.txd_level;
   assign rsp_xck_pulse = out_rsp.xck_pulse;
   assign rsp_busy_res  = out_rsp.busy_res;
   assign rsp_rx_byte   = out_rsp.rx_byte;
   assign rsp_rx_valid  = out_rsp.rx_valid;
   assign rsp_done_res  = out_rsp.done_res;
   assign rsp_status    = out_rsp.status;

endmodule

`default_nettype wire

FILE: verif/sync_serial_frame_transceiver_top_tb.sv
// Self-checking testbench for the synchronous serial frame transceiver top level.
`timescale 1ns / 1ps

module sync_serial_frame_transceiver_top_tb;
   import ssft_pkg::*;

   localparam int DATA_BITS = DATA_BITS_DEF;

   // Parity codes that the package leaves unnamed.
   localparam logic [1:0] PARITY_NONE   = 2'd0;
   localparam logic [1:0] PARITY_UNUSED = 2'd3;

   // One bit period as offered on the request side.
   typedef struct packed {
      req_kind_type kind;
      logic [7:0]   tx_byte;
      logic [15:0]  count;
      logic         pulse_level;
      logic         selected;
      logic         rxd;
   } period_item_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic                   full;
   logic [1:0]             req_type = REQ_NONE;
   logic [7:0]             req_tx_byte = '0;
   logic [15:0]            req_count = '0;
   logic                   req_pulse_level = 1'b0;
   logic                   req_slave_selected = 1'b0;
   logic                   req_rxd_sample = 1'b0;
   logic                   empty;
   logic                   pop = 1'b0;
   logic                   rsp_txd_level;
   logic                   rsp_xck_pulse;
   logic                   rsp_busy_res;
   logic [7:0]             rsp_rx_byte;
   logic                   rsp_rx_valid;
   logic                   rsp_done_res;
   logic [2:0]             rsp_status;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_ENABLED;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   sync_serial_frame_transceiver_top #(
      .DATA_BITS   (DATA_BITS),
      .QUEUE_DEPTH (QUEUE_DEPTH_DEF)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_type           (req_type),
      .req_tx_byte        (req_tx_byte),
      .req_count          (req_count),
      .req_pulse_level    (req_pulse_level),
      .req_slave_selected (req_slave_selected),
      .req_rxd_sample     (req_rxd_sample),
      .empty              (empty),
      .pop                (pop),
      .rsp_txd_level      (rsp_txd_level),
      .rsp_xck_pulse      (rsp_xck_pulse),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_rx_byte        (rsp_rx_byte),
      .rsp_rx_valid       (rsp_rx_valid),
      .rsp_done_res       (rsp_done_res),
      .rsp_status         (rsp_status),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Items waiting to be offered, and results predicted for accepted items.
   period_item_type pending_items[$];
   rsp_type         expected_results[$];
   int unsigned     items_queued = 0;
   int unsigned     fault_count = 0;

   // Predictor copy of the register file, at its reset values.
   cfg_type     eng_cfg = '{enabled: 1'b0, parity_mode: PARITY_NONE, two_stop_bits: 1'b0,
                            start_wait_limit: START_WAIT_RESET};
   logic [15:0] eng_half_period = 16'd1;

   // Predictor copy of the frame engine state.
   mode_type    eng_mode = MODE_IDLE;
   phase_type   eng_phase = PH_START;
   logic [3:0]  eng_bits = '0;
   logic [7:0]  eng_shift = '0;
   logic        eng_par = 1'b0;
   logic [15:0] eng_wait = '0;
   logic [15:0] eng_left = '0;
   logic        eng_txd = 1'b0;

   // Sender burst shaping and receiver stall pattern.
   period_item_type cur_item;
   int unsigned     burst_left = 8;
   int unsigned     gap_left = 0;
   logic [15:0]     stall_pattern = 16'hFFFF;
   int unsigned     pattern_age = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Frame engine predictor
   // ---------------------------------------------------------------------------------------

   function automatic logic parity_enabled();
      return eng_cfg.parity_mode == PARITY_EVEN || eng_cfg.parity_mode == PARITY_ODD;
   endfunction

   function automatic logic parity_sense();
      return eng_cfg.parity_mode == PARITY_ODD;
   endfunction

   function automatic void finish_op(inout rsp_type r, input status_type st);
      eng_mode    = MODE_IDLE;
      eng_phase   = PH_START;
      r.done_res  = 1'b1;
      r.status    = st;
   endfunction

   // After the last stop bit a receive either ends or hunts for the next start bit.
   function automatic void close_frame(inout rsp_type r);
      eng_left = eng_left - 16'd1;
      if (eng_left == 16'd0) begin
         finish_op(r, STATUS_OK);
      end else begin
         eng_phase = PH_START;
         eng_wait  = '0;
      end
   endfunction

   function automatic void send_period(inout rsp_type r);
      logic b;
      b = 1'b1;
      case (eng_phase)
         PH_START: begin
            b         = 1'b0;
            eng_phase = PH_DATA;
            eng_bits  = '0;
            eng_par   = 1'b0;
         end
         PH_DATA: begin
            b         = eng_shift[0];
            eng_shift = eng_shift >> 1;
            eng_par   = eng_par ^ b;
            eng_bits  = eng_bits + 4'd1;
            if (eng_bits >= DATA_BITS) begin
               if (parity_enabled()) eng_phase = PH_PARITY;
               else eng_phase = PH_STOP1;
            end
         end
         PH_PARITY: begin
            b         = eng_par ^ parity_sense();
            eng_phase = PH_STOP1;
         end
         PH_STOP1: begin
            if (eng_cfg.two_stop_bits) eng_phase = PH_STOP2;
            else finish_op(r, STATUS_OK);
         end
         default: begin
            finish_op(r, STATUS_OK);
         end
      endcase
      eng_txd     = b;
      r.txd_level = b;
      r.xck_pulse = 1'b1;
   endfunction

   function automatic void recv_period(inout rsp_type r, input logic rxd);
      r.xck_pulse = 1'b1;
      case (eng_phase)
         PH_START: begin
            if (!rxd) begin
               eng_phase = PH_DATA;
               eng_bits  = '0;
               eng_shift = '0;
               eng_par   = 1'b0;
            end else begin
               eng_wait = eng_wait + 16'd1;
               if (eng_wait >= eng_cfg.start_wait_limit) finish_op(r, STATUS_TIMEOUT);
            end
         end
         PH_DATA: begin
            eng_shift = {rxd, eng_shift[7:1]};
            eng_par   = eng_par ^ rxd;
            eng_bits  = eng_bits + 4'd1;
            if (eng_bits >= DATA_BITS) begin
               r.rx_valid = 1'b1;
               r.rx_byte  = eng_shift;
               if (parity_enabled()) eng_phase = PH_PARITY;
               else eng_phase = PH_STOP1;
            end
         end
         PH_PARITY: begin
            if (rxd != (eng_par ^ parity_sense())) finish_op(r, STATUS_PARITY_ERR);
            else eng_phase = PH_STOP1;
         end
         PH_STOP1: begin
            if (!rxd) finish_op(r, STATUS_STOP1_ERR);
            else if (eng_cfg.two_stop_bits) eng_phase = PH_STOP2;
            else close_frame(r);
         end
         default: begin
            if (!rxd) finish_op(r, STATUS_STOP2_ERR);
            else close_frame(r);
         end
      endcase
   endfunction

   function automatic void pulse_period(inout rsp_type r);
      r.txd_level = eng_txd;
      r.xck_pulse = 1'b1;
      eng_left    = eng_left - 16'd1;
      if (eng_left == 16'd0) finish_op(r, STATUS_OK);
   endfunction

   // Works out the result of one accepted bit period and advances the engine.
   function automatic rsp_type predict_bit_period(input period_item_type it);
      rsp_type r;
      r           = '0;
      r.status    = STATUS_OK;
      r.txd_level = eng_txd;
      if (eng_mode == MODE_IDLE && it.kind != REQ_NONE) begin
         if (!eng_cfg.enabled || !it.selected) begin
            finish_op(r, STATUS_REJECTED);
         end else begin
            case (it.kind)
               REQ_SEND: begin
                  eng_mode  = MODE_TX;
                  eng_phase = PH_START;
                  eng_shift = it.tx_byte;
                  send_period(r);
               end
               REQ_RECV: begin
                  if (it.count == 16'd0) begin
                     finish_op(r, STATUS_OK);
                  end else begin
                     eng_mode  = MODE_RX;
                     eng_phase = PH_START;
                     eng_left  = it.count;
                     eng_wait  = '0;
                     recv_period(r, it.rxd);
                  end
               end
               default: begin
                  eng_txd     = it.pulse_level;
                  r.txd_level = it.pulse_level;
                  if (it.count == 16'd0) begin
                     finish_op(r, STATUS_OK);
                  end else begin
                     eng_mode = MODE_PULSE;
                     eng_left = it.count;
                     pulse_period(r);
                  end
               end
            endcase
         end
      end else if (eng_mode == MODE_TX) begin
         send_period(r);
      end else if (eng_mode == MODE_RX) begin
         recv_period(r, it.rxd);
      end else if (eng_mode == MODE_PULSE) begin
         pulse_period(r);
      end
      r.busy_res = (eng_mode != MODE_IDLE);
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------------------------

   // Items are offered in bursts; the prediction is made at the edge that accepts an item.
   always @(posedge clock) begin : driver_proc
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) expected_results.push_back(predict_bit_period(cur_item));
         if (!push || !full) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               push <= 1'b0;
            end else if (pending_items.size() != 0) begin
               cur_item = pending_items.pop_front();
               req_type           <= cur_item.kind;
               req_tx_byte        <= cur_item.tx_byte;
               req_count          <= cur_item.count;
               req_pulse_level    <= cur_item.pulse_level;
               req_slave_selected <= cur_item.selected;
               req_rxd_sample     <= cur_item.rxd;
               push               <= 1'b1;
               if (burst_left > 1) begin
                  burst_left = burst_left - 1;
               end else begin
                  burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result monitor
   // ---------------------------------------------------------------------------------------

   // Each accepted result is checked against the oldest prediction.
   always @(posedge clock) begin : monitor_proc
      rsp_type got;
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            got.txd_level = rsp_txd_level;
            got.xck_pulse = rsp_xck_pulse;
            got.busy_res  = rsp_busy_res;
            got.rx_byte   = rsp_rx_byte;
            got.rx_valid  = rsp_rx_valid;
            got.done_res  = rsp_done_res;
            got.status    = status_type'(rsp_status);
            if (expected_results.size() == 0) begin
               if (fault_count < 10)
                  $display("%0t: result with no item outstanding: txd=%b xck=%b status=%0d",
                           $realtime, got.txd_level, got.xck_pulse, got.status);
               fault_count = fault_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got.txd_level !== want.txd_level || got.xck_pulse !== want.xck_pulse ||
                   got.busy_res !== want.busy_res || got.rx_byte !== want.rx_byte ||
                   got.rx_valid !== want.rx_valid || got.done_res !== want.done_res ||
                   got.status !== want.status) begin
                  if (fault_count < 10) begin
                     $display("%0t: mismatch, expected txd=%b xck=%b busy=%b byte=%h valid=%b done=%b status=%0d",
                              $realtime, want.txd_level, want.xck_pulse, want.busy_res,
                              want.rx_byte, want.rx_valid, want.done_res, want.status);
                     $display("%0t:           actual txd=%b xck=%b busy=%b byte=%h valid=%b done=%b status=%0d",
                              $realtime, got.txd_level, got.xck_pulse, got.busy_res,
                              got.rx_byte, got.rx_valid, got.done_res, got.status);
                  end
                  fault_count = fault_count + 1;
               end
            end
         end
         // The stall pattern rotates, and is replaced now and then.
         pattern_age = pattern_age + 1;
         if (pattern_age >= 50) begin
            pattern_age = 0;
            case ($urandom_range(0, 3))
               0:       stall_pattern = 16'hFFFF;
               1:       stall_pattern = 16'h0001;
               default: stall_pattern = 16'($urandom) | 16'h0001;
            endcase
         end else begin
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         end
         pop <= stall_pattern[0];
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------

   function automatic void queue_item(input req_kind_type k, input logic [7:0] b,
                                      input logic [15:0] n, input logic lvl,
                                      input logic sel, input logic rxd);
      period_item_type it;
      it.kind        = k;
      it.tx_byte     = b;
      it.count       = n;
      it.pulse_level = lvl;
      it.selected    = sel;
      it.rxd         = rxd;
      pending_items.push_back(it);
      items_queued = items_queued + 1;
   endfunction

   // A period that carries on the current operation; now and then a request that is ignored.
   function automatic void queue_continue(input logic rxd);
      req_kind_type k;
      k = REQ_NONE;
      if ($urandom_range(0, 7) == 0) k = req_kind_type'($urandom_range(1, 3));
      queue_item(k, 8'($urandom), 16'($urandom_range(0, 31)), 1'($urandom),
                 1'($urandom), rxd);
   endfunction

   // A receive request with well-formed frames, now and then broken on purpose.
   task automatic queue_receive(input bit big);
      logic        samples[$];
      int unsigned cnt;
      int unsigned frames;
      int unsigned limit_eff;
      int unsigned waits;
      logic [7:0]  data;
      logic        bad;
      bit          stop_now;
      cnt       = big ? $urandom_range(1, 65535) : $urandom_range(1, 3);
      frames    = big ? $urandom_range(1, 2) : cnt;
      limit_eff = (eng_cfg.start_wait_limit == 16'd0) ? 1 : eng_cfg.start_wait_limit;
      stop_now  = 1'b0;
      for (int f = 0; f < frames && !stop_now; f++) begin
         if (limit_eff <= 40 && $urandom_range(0, 7) == 0) begin
            // No start bit within the limit.
            repeat (limit_eff) samples.push_back(1'b1);
            stop_now = 1'b1;
         end else begin
            waits = $urandom_range(0, (limit_eff - 1 < 4) ? limit_eff - 1 : 4);
            repeat (waits) samples.push_back(1'b1);
            samples.push_back(1'b0);
            data = 8'($urandom);
            for (int i = 0; i < DATA_BITS; i++) samples.push_back(data[i]);
            if (parity_enabled()) begin
               bad = ($urandom_range(0, 9) == 0);
               samples.push_back(^data ^ parity_sense() ^ bad);
               stop_now = bad;
            end
            if (!stop_now) begin
               // A long count is cut short by a bad stop bit on its last frame.
               bad = ($urandom_range(0, 9) == 0) || (big && f == frames - 1);
               samples.push_back(!bad);
               stop_now = bad;
            end
            if (!stop_now && eng_cfg.two_stop_bits) begin
               bad = ($urandom_range(0, 9) == 0);
               samples.push_back(!bad);
               stop_now = bad;
            end
         end
      end
      queue_item(REQ_RECV, 8'($urandom), 16'(cnt), 1'($urandom), 1'b1, samples[0]);
      for (int i = 1; i < samples.size(); i++) queue_continue(samples[i]);
   endtask

   // Random traffic for one register setting: mostly whole operations, some noise.
   task automatic generate_traffic(input int unsigned budget);
      int unsigned target;
      int unsigned len;
      int unsigned pick;
      req_kind_type k;
      target = items_queued + budget;
      while (items_queued < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            queue_receive($urandom_range(0, 6) == 0);
         end else if (pick < 65) begin
            len = 1 + DATA_BITS + (parity_enabled() ? 1 : 0) + (eng_cfg.two_stop_bits ? 2 : 1);
            queue_item(REQ_SEND, 8'($urandom), 16'($urandom), 1'($urandom), 1'b1,
                       1'($urandom));
            repeat (len - 1) queue_continue(1'($urandom));
         end else if (pick < 80) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(0, 12);
            queue_item(REQ_PULSE, 8'($urandom), 16'(len), 1'($urandom), 1'b1, 1'($urandom));
            if (len > 1) repeat (len - 1) queue_continue(1'($urandom));
         end else if (pick < 90) begin
            // A request followed by a ragged run of random periods.
            k = req_kind_type'($urandom_range(1, 3));
            queue_item(k, 8'($urandom),
                       (k == REQ_PULSE) ? 16'($urandom_range(0, 31)) : 16'($urandom),
                       1'($urandom), 1'b1, 1'($urandom));
            repeat ($urandom_range(0, 12)) queue_continue(1'($urandom));
         end else begin
            repeat ($urandom_range(1, 3)) begin
               k = req_kind_type'($urandom_range(0, 3));
               queue_item(k, 8'($urandom),
                          (k == REQ_PULSE) ? 16'($urandom_range(0, 31)) : 16'($urandom),
                          1'($urandom), ($urandom_range(0, 3) != 0), 1'($urandom));
            end
         end
      end
   endtask

   // Returns once every queued item has been accepted and every result has arrived.
   task automatic wait_for_quiet();
      while (pending_items.size() != 0 || push || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Runs the engine back to idle so that the registers can be changed safely.
   task automatic settle_engine();
      wait_for_quiet();
      while (eng_mode != MODE_IDLE) begin
         repeat (8) queue_item(REQ_NONE, 8'($urandom), 16'($urandom), 1'($urandom),
                               1'($urandom), 1'b0);
         wait_for_quiet();
      end
   endtask

   // Writes every register in turn; called while the engine is idle.
   task automatic write_config(input cfg_type c, input logic [15:0] half);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ENABLED;
      csr_wdata <= CSR_DATA_W'(c.enabled);
      @(posedge clock);
      csr_index <= CSR_PARITY_MODE;
      csr_wdata <= CSR_DATA_W'(c.parity_mode);
      @(posedge clock);
      csr_index <= CSR_TWO_STOP;
      csr_wdata <= CSR_DATA_W'(c.two_stop_bits);
      @(posedge clock);
      csr_index <= CSR_HALF_PERIOD;
      csr_wdata <= half;
      @(posedge clock);
      csr_index <= CSR_START_WAIT;
      csr_wdata <= c.start_wait_limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      eng_cfg         = c;
      eng_half_period = half;
   endtask

   task automatic run_phase(input logic en, input logic [1:0] par, input logic two,
                            input logic [15:0] half, input logic [15:0] lim,
                            input int unsigned budget);
      cfg_type c;
      c.enabled          = en;
      c.parity_mode      = par;
      c.two_stop_bits    = two;
      c.start_wait_limit = lim;
      write_config(c, half);
      generate_traffic(budget);
      settle_engine();
   endtask

   initial begin : stimulus_proc
      cfg_type c;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Registers still at their reset values: every request is rejected.
      generate_traffic(12);
      settle_engine();

      // Directed periods: one stop bit, no parity, start wait of two periods.
      c.enabled          = 1'b1;
      c.parity_mode      = PARITY_NONE;
      c.two_stop_bits    = 1'b0;
      c.start_wait_limit = 16'd2;
      write_config(c, 16'd1);
      queue_item(REQ_NONE, 8'hFF, 16'hFFFF, 1'b1, 1'b0, 1'b1);
      // Unselected slave.
      queue_item(REQ_SEND, 8'h5A, 16'h0000, 1'b0, 1'b0, 1'b0);
      // Zero counts: a pulse still sets TXD to its level, a receive just ends.
      queue_item(REQ_PULSE, 8'h00, 16'h0000, 1'b1, 1'b1, 1'b0);
      queue_item(REQ_RECV, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b1);
      // Two pulses at a low level; a send arriving meanwhile is ignored.
      queue_item(REQ_PULSE, 8'hFF, 16'd2, 1'b0, 1'b1, 1'b1);
      queue_item(REQ_SEND, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b0);
      // The largest receive count, ended by a start timeout.
      queue_item(REQ_RECV, 8'h00, 16'hFFFF, 1'b0, 1'b1, 1'b1);
      queue_item(REQ_NONE, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b1);
      // A full frame of ones, with the slave deselected part way through.
      queue_item(REQ_SEND, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
      repeat (9) queue_item(REQ_NONE, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0);
      queue_item(REQ_NONE, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b0);
      settle_engine();

      // The sender also pauses for an empty pipeline at every change of setting.
      run_phase(1'b1, PARITY_EVEN,   1'b1, 16'd0,          16'd3,          180);
      run_phase(1'b1, PARITY_ODD,    1'b0, 16'hFFFF,       16'hFFFF,       180);
      run_phase(1'b1, PARITY_UNUSED, 1'b1, 16'($urandom),  16'd0,          160);
      run_phase(1'b0, PARITY_EVEN,   1'b0, 16'd5,          16'd10,         60);
      run_phase(1'b1, PARITY_NONE,   1'b0, 16'd1,          16'd1,          160);
      run_phase(1'b1, PARITY_ODD,    1'b1, 16'($urandom),
                16'($urandom_range(1, 40)), 180);
      run_phase(1'b1, PARITY_EVEN,   1'b0, 16'($urandom),  16'd1000,       180);

      wait_for_quiet();
      repeat (8) @(posedge clock);
      if (fault_count == 0 && expected_results.size() == 0) begin
         $display("sync_serial_frame_transceiver_top_tb: done, clean");
      end else begin
         $display("sync_serial_frame_transceiver_top_tb: done, errors");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin : watchdog_proc
      #(64'd4_000_000);
      $display("sync_serial_frame_transceiver_top_tb: done, errors");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ssft_pkg.sv
rtl/ssft_queue.sv
rtl/ssft_front.sv
rtl/ssft_back.sv
rtl/sync_serial_frame_transceiver_top.sv
verif/sync_serial_frame_transceiver_top_tb.sv
